@@ design/shbl_pkg.sv @@
// ----------------------------------------------------------------------------
// shbl_pkg: shared definitions of the serial hex byte loader
// Field widths, character codes, result codes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package shbl_pkg;

   // address space of the load memory
   localparam int unsigned ADDR_BITS  = 28;
   // width of the offset and count fields of a result
   localparam int unsigned FIELD_W    = 28;
   localparam int unsigned CHAR_W     = 8;
   localparam int unsigned NIBBLE_W   = 4;
   localparam int unsigned R_RUN_W    = 2;

   // consecutive 'r' characters that raise a reboot request
   localparam logic [R_RUN_W-1:0] REBOOT_RUN = 2'd3;

   // result queue geometry
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = 2;
   localparam int unsigned QUEUE_CNT_W = 3;

   // character codes
   localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UC_Z  = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_LC_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LC_F  = 8'h66;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_LC_R  = 8'h72;
   localparam logic [CHAR_W-1:0] CHAR_BANG  = 8'h21;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_HASH  = 8'h23;
   localparam logic [CHAR_W-1:0] CASE_BIT   = 8'h20;
   localparam logic [CHAR_W-1:0] HEX_LETTER_BASE = 8'd10;

   // input event codes
   typedef enum logic {
      KIND_CHAR    = 1'b0,
      KIND_TIMEOUT = 1'b1
   } in_kind_type;

   // result codes
   typedef enum logic [1:0] {
      OUT_ECHO   = 2'd0,
      OUT_WRITE  = 2'd1,
      OUT_REBOOT = 2'd2,
      OUT_START  = 2'd3
   } out_kind_type;

   // one result item
   typedef struct packed {
      out_kind_type          out_kind;
      logic [CHAR_W-1:0]     echo_char;
      logic [FIELD_W-1:0]    write_offset;
      logic [CHAR_W-1:0]     write_byte;
      logic [FIELD_W-1:0]    loaded_count;
      logic                  last;
   } result_type;

endpackage

`default_nettype wire

@@ design/shbl_req_if.sv @@
// ----------------------------------------------------------------------------
// shbl_req_if: input event channel
// Valid/ready channel that carries one received character or timeout event.
// ----------------------------------------------------------------------------
`default_nettype none

interface shbl_req_if;
   logic                             valid;
   logic                             ready;
   logic                             kind;
   logic [shbl_pkg::CHAR_W-1:0]      rx_char;

   modport source (output valid, output kind, output rx_char, input ready);
   modport sink   (input valid, input kind, input rx_char, output ready);
endinterface

`default_nettype wire

@@ design/shbl_rsp_if.sv @@
// ----------------------------------------------------------------------------
// shbl_rsp_if: result channel
// Valid/ready channel that carries one echo, write, reboot or start item.
// ----------------------------------------------------------------------------
`default_nettype none

interface shbl_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       out_kind;
   logic [shbl_pkg::CHAR_W-1:0]      echo_char;
   logic [shbl_pkg::FIELD_W-1:0]     write_offset;
   logic [shbl_pkg::CHAR_W-1:0]      write_byte;
   logic [shbl_pkg::FIELD_W-1:0]     loaded_count;
   logic                             last;

   modport source (output valid, output out_kind, output echo_char,
                   output write_offset, output write_byte,
                   output loaded_count, output last, input ready);
   modport sink   (input valid, input out_kind, input echo_char,
                   input write_offset, input write_byte,
                   input loaded_count, input last, output ready);
endinterface

`default_nettype wire

@@ design/serial_hex_byte_loader.sv @@
// ----------------------------------------------------------------------------
// serial_hex_byte_loader: serial hex byte loader
// Decodes characters into memory byte writes, echoes and boot requests.
// ----------------------------------------------------------------------------
// The results of an accepted item are registered into the result queue and presented from its head.
// Throughput: one item per cycle while the sink takes one result per cycle and
// items carry at most one result; an item with two results (CR, low hex nibble)
// needs the single result port for both, so a stream of those runs slower.
// The four-entry result queue accepts an item while it holds two or fewer.
// Reset (synchronous, active high) empties the queue and clears loader state.
`default_nettype none

module serial_hex_byte_loader (
   input  wire              clock,
   input  wire              reset,
   shbl_req_if.sink         req_chan,
   shbl_rsp_if.source       rsp_chan
);

   // loader state
   logic                                  expect_high_ff, expect_high_in;
   logic [shbl_pkg::NIBBLE_W-1:0]         high_part_ff, high_part_in;
   logic [shbl_pkg::ADDR_BITS-1:0]        next_offset_ff, next_offset_in;
   logic [shbl_pkg::R_RUN_W-1:0]          r_run_ff, r_run_in;

   // result queue
   shbl_pkg::result_type                  queue_ff [shbl_pkg::QUEUE_DEPTH];
   logic [shbl_pkg::QUEUE_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [shbl_pkg::QUEUE_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [shbl_pkg::QUEUE_CNT_W-1:0]      count_ff, count_in;

   // decode signals
   logic [shbl_pkg::CHAR_W-1:0]           folded_char;
   logic [shbl_pkg::NIBBLE_W-1:0]         digit;
   logic                                  is_letter_hex, is_number;
   logic [shbl_pkg::R_RUN_W-1:0]          r_run_next;
   shbl_pkg::result_type                  res0, res1, blank;
   logic [1:0]                            res_num;
   logic                                  accept, pop;
   logic [shbl_pkg::QUEUE_PTR_W-1:0]      wr_ptr_plus1;

   assign accept = req_chan.valid && req_chan.ready;
   assign pop    = rsp_chan.valid && rsp_chan.ready;

   // take an item while the queue has room for two results
   assign req_chan.ready =
      (count_ff <= shbl_pkg::QUEUE_CNT_W'(shbl_pkg::QUEUE_DEPTH - 2));

   // fold upper case letters to lower case
   always_comb begin
      folded_char = req_chan.rx_char;
      if ((req_chan.rx_char >= shbl_pkg::CHAR_UC_A) &&
          (req_chan.rx_char <= shbl_pkg::CHAR_UC_Z)) begin
         folded_char = req_chan.rx_char | shbl_pkg::CASE_BIT;
      end
   end

   // classify hex digits and take their value
   always_comb begin
      is_letter_hex = (folded_char >= shbl_pkg::CHAR_LC_A) &&
                      (folded_char <= shbl_pkg::CHAR_LC_F);
      is_number     = (folded_char >= shbl_pkg::CHAR_ZERO) &&
                      (folded_char <= shbl_pkg::CHAR_NINE);
      if (is_letter_hex) begin
         digit = shbl_pkg::NIBBLE_W'(folded_char - shbl_pkg::CHAR_LC_A +
                                     shbl_pkg::HEX_LETTER_BASE);
      end else begin
         digit = shbl_pkg::NIBBLE_W'(folded_char - shbl_pkg::CHAR_ZERO);
      end
      r_run_next = r_run_ff + 1'b1;
   end

   // build the results and next loader state of the offered item
   always_comb begin
      blank              = '0;
      blank.out_kind     = shbl_pkg::OUT_ECHO;
      res0               = blank;
      res1               = blank;
      res_num            = 2'd0;
      expect_high_in     = expect_high_ff;
      high_part_in       = high_part_ff;
      next_offset_in     = next_offset_ff;
      r_run_in           = r_run_ff;

      if (req_chan.kind == shbl_pkg::KIND_TIMEOUT) begin
         res0.echo_char = shbl_pkg::CHAR_HASH;
         res_num        = 2'd1;
      end else begin
         // count a run of 'r', clear it on anything else
         if (folded_char == shbl_pkg::CHAR_LC_R) begin
            if (r_run_ff < shbl_pkg::REBOOT_RUN) begin
               r_run_in = r_run_next;
               if (r_run_next == shbl_pkg::REBOOT_RUN) begin
                  res0.out_kind = shbl_pkg::OUT_REBOOT;
                  res_num       = 2'd1;
               end
            end
         end else begin
            r_run_in = '0;
         end

         if (folded_char == shbl_pkg::CHAR_CR) begin
            res0.echo_char = shbl_pkg::CHAR_CR;
            res1.echo_char = shbl_pkg::CHAR_LF;
            res_num        = 2'd2;
         end else if (folded_char == shbl_pkg::CHAR_BANG) begin
            res0.out_kind     = shbl_pkg::OUT_START;
            res0.loaded_count = shbl_pkg::FIELD_W'(next_offset_ff);
            res_num           = 2'd1;
         end else if (is_letter_hex || is_number) begin
            if (expect_high_ff) begin
               high_part_in   = digit;
               expect_high_in = 1'b0;
            end else begin
               res0.out_kind     = shbl_pkg::OUT_WRITE;
               res0.write_offset = shbl_pkg::FIELD_W'(next_offset_ff);
               res0.write_byte   = {high_part_ff, digit};
               res1.echo_char    = shbl_pkg::CHAR_DOT;
               res_num           = 2'd2;
               next_offset_in    = next_offset_ff + 1'b1;
               expect_high_in    = 1'b1;
            end
         end
      end

      // mark the final result of the item
      if (res_num == 2'd2) begin
         res1.last = 1'b1;
      end else begin
         res0.last = 1'b1;
      end
   end

   // advance queue pointers and fill count
   always_comb begin
      wr_ptr_plus1 = wr_ptr_ff + 1'b1;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      count_in     = count_ff;
      if (accept) begin
         wr_ptr_in = wr_ptr_ff + shbl_pkg::QUEUE_PTR_W'(res_num);
         count_in  = count_ff + shbl_pkg::QUEUE_CNT_W'(res_num);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
         count_in  = count_in - 1'b1;
      end
   end

   // hold control and loader state
   always_ff @(posedge clock) begin
      if (reset) begin
         expect_high_ff <= 1'b1;
         high_part_ff   <= '0;
         next_offset_ff <= '0;
         r_run_ff       <= '0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         count_ff       <= '0;
      end else begin
         if (accept) begin
            expect_high_ff <= expect_high_in;
            high_part_ff   <= high_part_in;
            next_offset_ff <= next_offset_in;
            r_run_ff       <= r_run_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store results of an accepted item
   always_ff @(posedge clock) begin
      if (accept && (res_num != 2'd0)) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (accept && (res_num == 2'd2)) begin
         queue_ff[wr_ptr_plus1] <= res1;
      end
   end

   // drive the head result
   assign rsp_chan.valid        = (count_ff != '0);
   assign rsp_chan.out_kind     = queue_ff[rd_ptr_ff].out_kind;
   assign rsp_chan.echo_char    = queue_ff[rd_ptr_ff].echo_char;
   assign rsp_chan.write_offset = queue_ff[rd_ptr_ff].write_offset;
   assign rsp_chan.write_byte   = queue_ff[rd_ptr_ff].write_byte;
   assign rsp_chan.loaded_count = queue_ff[rd_ptr_ff].loaded_count;
   assign rsp_chan.last         = queue_ff[rd_ptr_ff].last;

endmodule

`default_nettype wire
